@@ hdl/tcw_pkg.sv @@
// Shared constants, codes and types of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int INDEX_W = 11;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
	localparam logic [CELL_W-1:0] ERASE_CELL = 16'h0B20;

	typedef struct packed {
		logic we;
		logic re;
		logic scroll;
		logic home;
	} tcw_mem_ctl_t;

endpackage

@@ hdl/tcw_in_if.sv @@
// Input channel of the text console writer: put, clear and read items.
`timescale 1ns / 1ps
interface tcw_in_if import tcw_pkg::*;;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [CHAR_W-1:0]   char_code;
	logic [COLOR_W-1:0]  color;
	logic [INDEX_W-1:0]  cell_index;

	modport source (output valid, kind, char_code, color, cell_index, input ready);
	modport sink (input valid, kind, char_code, color, cell_index, output ready);
endinterface

@@ hdl/tcw_out_if.sv @@
// Result channel of the text console writer: cursor, scroll flag and read data.
`timescale 1ns / 1ps
interface tcw_out_if import tcw_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   cursor_col;
	logic [ROW_W-1:0]   cursor_row;
	logic [POS_W-1:0]   cursor_pos;
	logic               scrolled;
	logic [CELL_W-1:0]  read_data;

	modport source (output valid, cursor_col, cursor_row, cursor_pos, scrolled, read_data,
		input ready);
	modport sink (input valid, cursor_col, cursor_row, cursor_pos, scrolled, read_data,
		output ready);
endinterface

@@ hdl/tcw_screen.sv @@
// Cell memory of the console, kept as a ring of rows addressed through a base offset.
`timescale 1ns / 1ps
module tcw_screen import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcw_mem_ctl_t      ctl,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELLS];
	logic [AW-1:0]     base_q;
	logic [AW:0]       wsum, rsum, bsum;
	logic [AW-1:0]     wphys, rphys, base_next;

	always_comb begin
		wsum = (AW+1)'(waddr) + (AW+1)'(base_q);
		rsum = (AW+1)'(raddr) + (AW+1)'(base_q);
		bsum = (AW+1)'(base_q) + (AW+1)'(COLUMNS);
		if (wsum >= (AW+1)'(CELLS)) begin
			wphys = AW'(wsum - (AW+1)'(CELLS));
		end else begin
			wphys = AW'(wsum);
		end
		if (rsum >= (AW+1)'(CELLS)) begin
			rphys = AW'(rsum - (AW+1)'(CELLS));
		end else begin
			rphys = AW'(rsum);
		end
		if (bsum >= (AW+1)'(CELLS)) begin
			base_next = AW'(bsum - (AW+1)'(CELLS));
		end else begin
			base_next = AW'(bsum);
		end
	end

	// scrolling moves the base down one row; the recycled row is refilled by the caller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (ctl.home) begin
			base_q <= '0;
		end else if (ctl.scroll) begin
			base_q <= base_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[wphys] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[rphys];
		end
	end

endmodule

@@ hdl/text_console_writer.sv @@
// Top level of the text console writer: item sequencer, cursor and result register.
//
//   channel   | dir | carries
//   ----------+-----+------------------------------------------------
//   item_in   | in  | kind, char_code, color, cell_index
//   res_out   | out | cursor_col, cursor_row, cursor_pos, scrolled, read_data
//
// A put, read or ignored item passes from ST_EXEC to ST_DONE, where it loads the result
// register, and the sequencer then returns to ST_IDLE for the next item. A put that scrolls
// blanks the recycled row in ST_FILL; a clear sweeps all COLUMNS*ROWS cells (2000 by default) there.
// After reset a clearing pass over all COLUMNS*ROWS cells runs with item_in.ready low.
// A new item is taken while a result still waits on res_out; it holds in the final
// state until the result register frees up.
`timescale 1ns / 1ps
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tcw_in_if.sink    item_in,
	tcw_out_if.source res_out
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);
	localparam int CLW   = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]          state_q, state_d;
	logic [KIND_W-1:0]   kind_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLOR_W-1:0]  color_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CLW-1:0]      col_q, col_d;
	logic [RW-1:0]       row_q, row_d;
	logic [AW-1:0]       fill_addr_q, fill_addr_d;
	logic [CNTW-1:0]     fill_left_q, fill_left_d;
	logic                fill_res_q, fill_res_d;
	logic                scrolled_q, scrolled_d;
	logic                rd_ok_q, rd_ok_d;
	logic                out_valid_q;
	logic [COL_W-1:0]    out_col_q;
	logic [ROW_W-1:0]    out_row_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                out_scr_q;
	logic [CELL_W-1:0]   out_data_q;

	tcw_mem_ctl_t        mem_ctl;
	logic [AW-1:0]       waddr, raddr;
	logic [CELL_W-1:0]   wdata, rdata;
	logic [CLW-1:0]      wr_col, adv_col;
	logic [RW-1:0]       wr_row;
	logic                row_inc;
	logic [AW-1:0]       wr_lin, cur_lin;
	logic [31:0]         col32, row32, pos32;
	logic                accept, out_load;

	assign accept        = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_DONE) && (!out_valid_q || res_out.ready);

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= item_in.kind;
			char_q  <= item_in.char_code;
			color_q <= item_in.color;
			idx_q   <= item_in.cell_index;
		end
	end

	assign wr_lin  = AW'(AW'(wr_row) * AW'(COLUMNS)) + AW'(wr_col);
	assign cur_lin = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);

	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		row_d       = row_q;
		fill_addr_d = fill_addr_q;
		fill_left_d = fill_left_q;
		fill_res_d  = fill_res_q;
		scrolled_d  = scrolled_q;
		rd_ok_d     = rd_ok_q;
		mem_ctl     = '0;
		wdata       = BLANK_CELL;
		raddr       = AW'(idx_q);
		wr_col      = col_q;
		wr_row      = row_q;
		adv_col     = col_q;
		row_inc     = 1'b0;
		waddr       = fill_addr_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				scrolled_d = 1'b0;
				rd_ok_d    = 1'b0;
				state_d    = ST_DONE;
				case (kind_q)
					KIND_PUT: begin
						if (char_q == CH_BACKSPACE) begin
							if (col_q != '0) begin
								wr_col = col_q - CLW'(1);
							end else if (row_q != '0) begin
								wr_row = row_q - RW'(1);
								wr_col = CLW'(COLUMNS - 1);
							end
							mem_ctl.we = 1'b1;
							wdata      = ERASE_CELL;
							col_d      = wr_col;
							row_d      = wr_row;
						end else begin
							if (char_q == CH_NEWLINE) begin
								adv_col = '0;
								row_inc = 1'b1;
							end else begin
								mem_ctl.we = 1'b1;
								wdata      = {color_q, char_q};
								if (col_q == CLW'(COLUMNS - 1)) begin
									adv_col = '0;
									row_inc = 1'b1;
								end else begin
									adv_col = col_q + CLW'(1);
								end
							end
							col_d = adv_col;
							if (row_inc) begin
								if (row_q == RW'(ROWS - 1)) begin
									mem_ctl.scroll = 1'b1;
									scrolled_d     = 1'b1;
									fill_addr_d    = AW'((ROWS - 1) * COLUMNS);
									fill_left_d    = CNTW'(COLUMNS);
									fill_res_d     = 1'b1;
									state_d        = ST_FILL;
								end else begin
									row_d = row_q + RW'(1);
								end
							end
						end
						waddr = wr_lin;
					end
					KIND_CLEAR: begin
						mem_ctl.home = 1'b1;
						col_d        = '0;
						row_d        = '0;
						fill_addr_d  = '0;
						fill_left_d  = CNTW'(CELLS);
						fill_res_d   = 1'b1;
						state_d      = ST_FILL;
					end
					KIND_READ: begin
						if (32'(idx_q) < 32'(CELLS)) begin
							mem_ctl.re = 1'b1;
							rd_ok_d    = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ST_FILL: begin
				mem_ctl.we  = 1'b1;
				wdata       = BLANK_CELL;
				waddr       = fill_addr_q;
				fill_addr_d = fill_addr_q + AW'(1);
				fill_left_d = fill_left_q - CNTW'(1);
				if (fill_left_q == CNTW'(1)) begin
					state_d = fill_res_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			col_q       <= '0;
			row_q       <= '0;
			fill_addr_q <= '0;
			fill_left_q <= CNTW'(CELLS);
			fill_res_q  <= 1'b0;
			scrolled_q  <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			col_q       <= col_d;
			row_q       <= row_d;
			fill_addr_q <= fill_addr_d;
			fill_left_q <= fill_left_d;
			fill_res_q  <= fill_res_d;
			scrolled_q  <= scrolled_d;
			rd_ok_q     <= rd_ok_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign col32 = 32'(col_q);
	assign row32 = 32'(row_q);
	assign pos32 = 32'(cur_lin);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_col_q  <= col32[COL_W-1:0];
			out_row_q  <= row32[ROW_W-1:0];
			out_pos_q  <= pos32[POS_W-1:0];
			out_scr_q  <= scrolled_q;
			out_data_q <= rd_ok_q ? rdata : '0;
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.cursor_col = out_col_q;
	assign res_out.cursor_row = out_row_q;
	assign res_out.cursor_pos = out_pos_q;
	assign res_out.scrolled   = out_scr_q;
	assign res_out.read_data  = out_data_q;

	tcw_screen #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_screen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the text console writer: put, clear and read items with cursor checks.
`timescale 1ns / 1ps
module tb_top;
	import tcw_pkg::*;

	localparam int NCOL = COLUMNS_DEF;
	localparam int NROW = ROWS_DEF;
	localparam int NCELL = NCOL * NROW;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 680;
	localparam int SEGMENT_LEN = 40;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 20;
	localparam int LIMIT_CYCLES = 1000000;

	typedef enum int {SEG_TEXT, SEG_SCROLL, SEG_NOISE} seg_t;

	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [POS_W-1:0]  pos;
		logic              scrolled;
		logic [CELL_W-1:0] data;
	} cursor_report_t;

	class console_scoreboard;
		logic [CELL_W-1:0] cells [NCELL];
		int cur_col;
		int cur_row;
		cursor_report_t due_reports [$];
		int errors;
		int checked;
		int n_reads;
		int n_scrolls;
		int n_clears;
		int n_wraps;

		function new();
			blank_all();
			errors = 0;
			checked = 0;
			n_reads = 0;
			n_scrolls = 0;
			n_clears = 0;
			n_wraps = 0;
		endfunction

		function void blank_all();
			foreach (cells[i]) cells[i] = BLANK_CELL;
			cur_col = 0;
			cur_row = 0;
		endfunction

		function logic advance_put(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color);
			if (ch == CH_BACKSPACE) begin
				if (cur_col > 0) begin
					cur_col--;
				end else if (cur_row > 0) begin
					cur_row--;
					cur_col = NCOL - 1;
					n_wraps++;
				end
				cells[cur_row * NCOL + cur_col] = ERASE_CELL;
				return 1'b0;
			end
			if (ch == CH_NEWLINE) begin
				cur_col = 0;
				cur_row++;
			end else begin
				cells[cur_row * NCOL + cur_col] = {color, ch};
				cur_col++;
				if (cur_col >= NCOL) begin
					cur_col = 0;
					cur_row++;
					n_wraps++;
				end
			end
			if (cur_row >= NROW) begin
				for (int i = 0; i < NCOL * (NROW - 1); i++) cells[i] = cells[i + NCOL];
				for (int i = NCOL * (NROW - 1); i < NCELL; i++) cells[i] = BLANK_CELL;
				cur_row = NROW - 1;
				n_scrolls++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void take_item(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
				logic [COLOR_W-1:0] color, logic [INDEX_W-1:0] idx);
			cursor_report_t r;
			int p;
			r = '0;
			case (kind)
				KIND_PUT: begin
					r.scrolled = advance_put(ch, color);
				end
				KIND_CLEAR: begin
					blank_all();
					n_clears++;
				end
				KIND_READ: begin
					n_reads++;
					if (idx < NCELL) r.data = cells[idx];
				end
				default: ;
			endcase
			p = cur_row * NCOL + cur_col;
			r.col = cur_col[COL_W-1:0];
			r.row = cur_row[ROW_W-1:0];
			r.pos = p[POS_W-1:0];
			due_reports.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(cursor_report_t got);
			cursor_report_t exp;
			if (due_reports.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", checked));
			end else begin
				exp = due_reports.pop_front();
				if (got.col !== exp.col)
					report($sformatf("result %0d cursor_col %0d, expected %0d",
						checked, got.col, exp.col));
				if (got.row !== exp.row)
					report($sformatf("result %0d cursor_row %0d, expected %0d",
						checked, got.row, exp.row));
				if (got.pos !== exp.pos)
					report($sformatf("result %0d cursor_pos %0d, expected %0d",
						checked, got.pos, exp.pos));
				if (got.scrolled !== exp.scrolled)
					report($sformatf("result %0d scrolled %0b, expected %0b",
						checked, got.scrolled, exp.scrolled));
				if (got.data !== exp.data)
					report($sformatf("result %0d read_data %h, expected %h",
						checked, got.data, exp.data));
			end
			checked++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int cycles = 0;
	int counted_items = 0;
	int burst_left = 0;
	console_scoreboard board = new();

	tcw_in_if item_in();
	tcw_out_if res_out();

	text_console_writer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.res_out(res_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	task offer(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
			logic [INDEX_W-1:0] idx);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 19);
			if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(10, 40);
		end
		@(negedge clk);
		if (gap > 0) begin
			item_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_in.kind <= kind;
		item_in.char_code <= ch;
		item_in.color <= color;
		item_in.cell_index <= idx;
		item_in.valid <= 1'b1;
		do @(posedge clk); while (!item_in.ready);
		board.take_item(kind, ch, color, idx);
		if (kind != KIND_UNUSED) counted_items++;
	endtask

	task read_index(output logic [INDEX_W-1:0] idx);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) idx = INDEX_W'($urandom_range(0, 2047));
		else if (roll == 1) idx = INDEX_W'($urandom_range(NCELL - NCOL, NCELL - 1));
		else idx = INDEX_W'($urandom_range(0, NCELL - 1));
	endtask

	task send_random(seg_t seg);
		int roll;
		logic [CHAR_W-1:0] ch;
		logic [COLOR_W-1:0] color;
		logic [INDEX_W-1:0] idx;
		roll = $urandom_range(0, 99);
		ch = CHAR_W'($urandom_range(0, 255));
		color = COLOR_W'($urandom_range(0, 255));
		read_index(idx);
		if ($urandom_range(0, 249) == 0) begin
			offer(KIND_CLEAR, ch, color, idx);
		end else if (seg == SEG_NOISE) begin
			offer(KIND_W'($urandom_range(0, 3)), ch, color,
				INDEX_W'($urandom_range(0, 2047)));
		end else if (seg == SEG_SCROLL) begin
			if (roll < 35) offer(KIND_PUT, CH_NEWLINE, color, idx);
			else if (roll < 85) offer(KIND_PUT, ch, color, idx);
			else offer(KIND_READ, ch, color, idx);
		end else begin
			if (roll < 60) offer(KIND_PUT, ch, color, idx);
			else if (roll < 70) offer(KIND_PUT, CH_NEWLINE, color, idx);
			else if (roll < 78) offer(KIND_PUT, CH_BACKSPACE, color, idx);
			else if (roll < 97) offer(KIND_READ, ch, color, idx);
			else offer(KIND_UNUSED, ch, color, idx);
		end
	endtask

	// result side: random stalls, quiet stretches, one long hold-off
	initial begin
		int stall;
		int got;
		int quiet;
		res_out.ready = 1'b0;
		got = 0;
		quiet = 0;
		forever begin
			if (quiet == 0 && $urandom_range(0, 7) == 0) quiet = $urandom_range(20, 60);
			if (got == HOLD_AT) begin
				stall = HOLD_CYCLES;
			end else if (quiet > 0) begin
				stall = 0;
				quiet--;
			end else begin
				stall = $urandom_range(0, 19);
			end
			if (stall > 0) begin
				@(negedge clk);
				res_out.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				res_out.ready <= 1'b1;
			end else if (res_out.ready !== 1'b1) begin
				@(negedge clk);
				res_out.ready <= 1'b1;
			end
			do @(posedge clk); while (res_out.valid !== 1'b1);
			board.check_result('{res_out.cursor_col, res_out.cursor_row, res_out.cursor_pos,
				res_out.scrolled, res_out.read_data});
			got++;
		end
	end

	initial begin
		seg_t seg;
		int roll;
		arst_n = 1'b0;
		item_in.valid = 1'b0;
		item_in.kind = KIND_PUT;
		item_in.char_code = '0;
		item_in.color = '0;
		item_in.cell_index = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: blank reads, out of range, backspace at home, high bytes, wraps
		offer(KIND_READ, 8'h00, 8'h00, 11'd0);
		offer(KIND_READ, 8'hFF, 8'hFF, 11'd1999);
		offer(KIND_READ, 8'h00, 8'h00, 11'd2000);
		offer(KIND_READ, 8'h00, 8'h00, 11'd2047);
		offer(KIND_PUT, CH_BACKSPACE, 8'hFF, 11'd0);
		offer(KIND_READ, 8'h00, 8'h00, 11'd0);
		offer(KIND_PUT, 8'h41, 8'h00, 11'd0);
		offer(KIND_PUT, 8'hFF, 8'hFF, 11'd2047);
		offer(KIND_PUT, 8'h80, 8'h07, 11'd0);
		offer(KIND_PUT, 8'h00, 8'h80, 11'd0);
		offer(KIND_READ, 8'h00, 8'h00, 11'd1);
		offer(KIND_READ, 8'h00, 8'h00, 11'd2);
		offer(KIND_READ, 8'h00, 8'h00, 11'd3);
		offer(KIND_PUT, CH_NEWLINE, 8'h0F, 11'd0);
		offer(KIND_PUT, CH_BACKSPACE, 8'h0F, 11'd0);
		offer(KIND_READ, 8'h00, 8'h00, 11'd79);
		offer(KIND_UNUSED, 8'hFF, 8'hFF, 11'd2047);
		offer(KIND_CLEAR, 8'h00, 8'h00, 11'd0);
		offer(KIND_READ, 8'h00, 8'h00, 11'd1);
		offer(KIND_PUT, 8'h20, 8'h0F, 11'd1024);

		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 9);
			seg = (roll < 5) ? SEG_TEXT : (roll < 8) ? SEG_SCROLL : SEG_NOISE;
			repeat (SEGMENT_LEN) send_random(seg);
		end

		@(negedge clk);
		item_in.valid <= 1'b0;
		while (board.due_reports.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d reads, %0d scrolls, %0d clears, %0d line wraps",
			board.checked, board.n_reads, board.n_scrolls, board.n_clears, board.n_wraps);
		$display("%0d mismatches in %0d cycles", board.errors, cycles);
		if (board.errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
hdl/tcw_pkg.sv
hdl/tcw_in_if.sv
hdl/tcw_out_if.sv
hdl/tcw_screen.sv
hdl/text_console_writer.sv
verif/tb_top.sv
